@@ design/fdm_pkg.sv @@
package fdm_pkg;

  // Fixed-point formats of the datapath.
  localparam int FRAC_BITS    = 8;
  localparam int NORM_FRAC    = 20;
  localparam int ANG_FRAC     = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS    = 31;
  localparam int SQRT_STEPS   = 32;

  // Largest frame size.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Configuration register indexes.
  localparam logic [2:0] REG_FOCAL_X   = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y   = 3'd1;
  localparam logic [2:0] REG_CENTER_X  = 3'd2;
  localparam logic [2:0] REG_CENTER_Y  = 3'd3;
  localparam logic [2:0] REG_COEF_ONE  = 3'd4;
  localparam logic [2:0] REG_COEF_TWO  = 3'd5;
  localparam logic [2:0] REG_COEF_THREE = 3'd6;
  localparam logic [2:0] REG_COEF_FOUR = 3'd7;

  // Register values after reset.
  localparam logic [23:0] FOCAL_X_RST  = 24'd183729;
  localparam logic [23:0] FOCAL_Y_RST  = 24'd183813;
  localparam logic [23:0] CENTER_X_RST = 24'd188090;
  localparam logic [23:0] CENTER_Y_RST = 24'd141330;
  localparam logic [31:0] COEF_ONE_RST   = 32'hFDC3_F4ED;
  localparam logic [31:0] COEF_TWO_RST   = 32'hFFFE_B6C0;
  localparam logic [31:0] COEF_THREE_RST = 32'h0006_2AA2;
  localparam logic [31:0] COEF_FOUR_RST  = 32'hFFFF_75EF;

  // 1.0 in the Q.30 angle and scale format.
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [30:0] NORM_LIMIT = 31'h7FFF_FFFF;

  localparam logic signed [32:0] ATAN_TAB [11] = '{
    33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
    33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
    33'sd4194283,   33'sd2097149,   33'sd1048576
  };

  // Arctangent of 2^-i in Q.30; beyond the table it equals 2^-i.
  function automatic logic signed [32:0] atan_entry(input int i);
    logic signed [32:0] v;
    if (i < 11) begin
      v = ATAN_TAB[i];
    end else begin
      v = 33'sd1 <<< (ANG_FRAC - i);
    end
    return v;
  endfunction

endpackage

@@ design/fisheye_distortion_map_top.sv @@
// Fisheye distortion map.
// For every output pixel position (column, row) taken on the slave stream,
// the block returns the fisheye source position on the master stream, as
// signed coordinates with 8 fraction bits, and a clipped flag in tuser when
// either coordinate saturated. Lens parameters are set through the
// configuration write channel, which is always ready; they must only be
// changed while no transfer is in flight in the pipeline.
// The datapath is a fixed pipeline of 141 register stages: two 31-stage
// restoring dividers, a 32-stage square root, a 30-stage CORDIC arctangent
// and a chain of multiplier stages. One item is taken per cycle while the
// receiver does not hold a waiting result back.
// When the receiver holds tready low while a result waits, the whole
// pipeline freezes, including the input tready; nothing is lost or repeated.
// Empty slots (bubbles) travel with their valid bits and are not squeezed out.
// Reset clears all valid bits and loads the default lens parameters.
module fisheye_distortion_map_top #(
  parameter int MAX_WIDTH  = fdm_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = fdm_pkg::MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [11:0] pixel_col, [23:12] pixel_row
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [23:0] src_x, [47:24] src_y
  output logic        m_axis_tuser_o,   // [0] clipped
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i
);

  localparam int LAT = 141;

  typedef struct packed {
    logic [23:0] ax;
    logic [23:0] ay;
    logic        negx;
    logic        negy;
    logic        zero;
  } side_t;

  typedef struct packed {
    side_t       sd;
    logic [23:0] rx;
    logic [23:0] ry;
    logic [30:0] qx;
    logic [30:0] qy;
    logic        ovx;
    logic        ovy;
  } div1_t;

  typedef struct packed {
    side_t       sd;
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    side_t              sd;
    logic [31:0]        r;
    logic signed [44:0] x;
    logic signed [44:0] y;
    logic signed [32:0] z;
  } cord_t;

  typedef struct packed {
    side_t       sd;
    logic [31:0] r;
    logic [30:0] theta;
    logic [31:0] rem;
    logic [30:0] q;
    logic        ov;
  } div2_t;

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [23:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [31:0] coef_one_q, coef_two_q, coef_three_q, coef_four_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q    <= fdm_pkg::FOCAL_X_RST;
      focal_y_q    <= fdm_pkg::FOCAL_Y_RST;
      center_x_q   <= fdm_pkg::CENTER_X_RST;
      center_y_q   <= fdm_pkg::CENTER_Y_RST;
      coef_one_q   <= fdm_pkg::COEF_ONE_RST;
      coef_two_q   <= fdm_pkg::COEF_TWO_RST;
      coef_three_q <= fdm_pkg::COEF_THREE_RST;
      coef_four_q  <= fdm_pkg::COEF_FOUR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        fdm_pkg::REG_FOCAL_X:    focal_x_q    <= cfg_data_i[23:0];
        fdm_pkg::REG_FOCAL_Y:    focal_y_q    <= cfg_data_i[23:0];
        fdm_pkg::REG_CENTER_X:   center_x_q   <= cfg_data_i[23:0];
        fdm_pkg::REG_CENTER_Y:   center_y_q   <= cfg_data_i[23:0];
        fdm_pkg::REG_COEF_ONE:   coef_one_q   <= cfg_data_i;
        fdm_pkg::REG_COEF_TWO:   coef_two_q   <= cfg_data_i;
        fdm_pkg::REG_COEF_THREE: coef_three_q <= cfg_data_i;
        fdm_pkg::REG_COEF_FOUR:  coef_four_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero focal length behaves as one.
  logic [23:0] fx_eff, fy_eff;
  assign fx_eff = (focal_x_q == '0) ? 24'd1 : focal_x_q;
  assign fy_eff = (focal_y_q == '0) ? 24'd1 : focal_y_q;

  // ---------------------------------------------------------------------
  // Pipeline control: every stage moves together. The pipeline advances
  // whenever the output register is empty or its transfer completes.
  // ---------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en              = ~vld_q[LAT-1] | m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  // ---------------------------------------------------------------------
  // Offset from the principal point. Coordinates beyond the frame are
  // held at the last column or row.
  // ---------------------------------------------------------------------
  logic [11:0]        col_c, row_c;
  logic signed [24:0] dx_q, dy_q, dx_d, dy_d;

  always_comb begin
    col_c = s_axis_tdata_i[11:0];
    row_c = s_axis_tdata_i[23:12];
    if (int'(col_c) > MAX_WIDTH - 1) begin
      col_c = 12'(MAX_WIDTH - 1);
    end
    if (int'(row_c) > MAX_HEIGHT - 1) begin
      row_c = 12'(MAX_HEIGHT - 1);
    end
    dx_d = $signed(25'({col_c, {fdm_pkg::FRAC_BITS{1'b0}}})) - $signed({1'b0, center_x_q});
    dy_d = $signed(25'({row_c, {fdm_pkg::FRAC_BITS{1'b0}}})) - $signed({1'b0, center_y_q});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // ---------------------------------------------------------------------
  // Normalization: |d| << 20 / focal, one quotient bit per stage. The
  // quotient saturates when |d| >= focal << 11; otherwise it fits 31 bits
  // and the top dividend bits start out below the divisor.
  // ---------------------------------------------------------------------
  div1_t d1_q [0:fdm_pkg::DIV_STEPS];
  div1_t d1_d0;

  always_comb begin
    d1_d0         = '0;
    d1_d0.sd.negx = dx_q[24];
    d1_d0.sd.negy = dy_q[24];
    d1_d0.sd.ax   = 24'(dx_q[24] ? -dx_q : dx_q);
    d1_d0.sd.ay   = 24'(dy_q[24] ? -dy_q : dy_q);
    d1_d0.ovx     = {11'b0, d1_d0.sd.ax} >= {fx_eff, 11'b0};
    d1_d0.ovy     = {11'b0, d1_d0.sd.ay} >= {fy_eff, 11'b0};
    d1_d0.rx      = 24'(d1_d0.sd.ax[23:11]);
    d1_d0.ry      = 24'(d1_d0.sd.ay[23:11]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= d1_d0;
    end
  end

  for (genvar k = 0; k < fdm_pkg::DIV_STEPS; k++) begin : g_div1
    localparam int B = fdm_pkg::DIV_STEPS - 1 - k;
    logic        bx, by;
    logic [24:0] tx, ty;
    div1_t       nx_d;

    if (B >= fdm_pkg::NORM_FRAC) begin : g_bit
      assign bx = d1_q[k].sd.ax[B - fdm_pkg::NORM_FRAC];
      assign by = d1_q[k].sd.ay[B - fdm_pkg::NORM_FRAC];
    end else begin : g_zero
      assign bx = 1'b0;
      assign by = 1'b0;
    end

    always_comb begin
      nx_d = d1_q[k];
      tx   = {d1_q[k].rx, bx};
      ty   = {d1_q[k].ry, by};
      if (tx >= {1'b0, fx_eff}) begin
        nx_d.rx = 24'(tx - {1'b0, fx_eff});
        nx_d.qx = {d1_q[k].qx[29:0], 1'b1};
      end else begin
        nx_d.rx = tx[23:0];
        nx_d.qx = {d1_q[k].qx[29:0], 1'b0};
      end
      if (ty >= {1'b0, fy_eff}) begin
        nx_d.ry = 24'(ty - {1'b0, fy_eff});
        nx_d.qy = {d1_q[k].qy[29:0], 1'b1};
      end else begin
        nx_d.ry = ty[23:0];
        nx_d.qy = {d1_q[k].qy[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d1_q[k+1] <= nx_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Squared radius.
  // ---------------------------------------------------------------------
  logic [30:0] nx_n, ny_n;
  side_t       sq_sd_q, sum_sd_q, sq_sd_d;
  logic [61:0] nx2_q, ny2_q;
  logic [62:0] r2_q;

  always_comb begin
    nx_n         = d1_q[fdm_pkg::DIV_STEPS].ovx ? fdm_pkg::NORM_LIMIT
                                                : d1_q[fdm_pkg::DIV_STEPS].qx;
    ny_n         = d1_q[fdm_pkg::DIV_STEPS].ovy ? fdm_pkg::NORM_LIMIT
                                                : d1_q[fdm_pkg::DIV_STEPS].qy;
    sq_sd_d      = d1_q[fdm_pkg::DIV_STEPS].sd;
    sq_sd_d.zero = (nx_n == '0) && (ny_n == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_sd_q  <= sq_sd_d;
      nx2_q    <= nx_n * nx_n;
      ny2_q    <= ny_n * ny_n;
      sum_sd_q <= sq_sd_q;
      r2_q     <= 63'(nx2_q) + 63'(ny2_q);
    end
  end

  // ---------------------------------------------------------------------
  // Integer square root, two radicand bits per stage.
  // ---------------------------------------------------------------------
  sqrt_t sr_d0;
  sqrt_t sr_q [1:fdm_pkg::SQRT_STEPS];

  always_comb begin
    sr_d0     = '0;
    sr_d0.sd  = sum_sd_q;
    sr_d0.rad = {1'b0, r2_q};
  end

  for (genvar j = 0; j < fdm_pkg::SQRT_STEPS; j++) begin : g_sqrt
    localparam int HI = 63 - 2 * j;
    sqrt_t       cur;
    logic [35:0] trem, trial;
    sqrt_t       ns_d;

    if (j == 0) begin : g_first
      assign cur = sr_d0;
    end else begin : g_next
      assign cur = sr_q[j];
    end

    always_comb begin
      ns_d  = cur;
      trem  = {cur.rem, cur.rad[HI -: 2]};
      trial = {2'b00, cur.root, 2'b01};
      if (trem >= trial) begin
        ns_d.rem  = 34'(trem - trial);
        ns_d.root = {cur.root[30:0], 1'b1};
      end else begin
        ns_d.rem  = trem[33:0];
        ns_d.root = {cur.root[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_q[j+1] <= ns_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Arctangent of r by CORDIC vectoring on (1.0, r), one rotation a stage.
  // ---------------------------------------------------------------------
  cord_t co_q [0:fdm_pkg::CORDIC_STEPS];
  cord_t co_d0;

  always_comb begin
    co_d0    = '0;
    co_d0.sd = sr_q[fdm_pkg::SQRT_STEPS].sd;
    co_d0.r  = sr_q[fdm_pkg::SQRT_STEPS].root;
    co_d0.x  = 45'sd1 <<< fdm_pkg::ANG_FRAC;
    co_d0.y  = $signed(45'({co_d0.r, 10'b0}));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      co_q[0] <= co_d0;
    end
  end

  for (genvar i = 0; i < fdm_pkg::CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [32:0] ANG = fdm_pkg::atan_entry(i);
    logic signed [44:0] xs, ys;
    cord_t              nc_d;

    always_comb begin
      nc_d = co_q[i];
      xs   = co_q[i].x >>> i;
      ys   = co_q[i].y >>> i;
      if (!co_q[i].y[44]) begin
        nc_d.x = co_q[i].x + ys;
        nc_d.y = co_q[i].y - xs;
        nc_d.z = co_q[i].z + ANG;
      end else begin
        nc_d.x = co_q[i].x - ys;
        nc_d.y = co_q[i].y + xs;
        nc_d.z = co_q[i].z - ANG;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        co_q[i+1] <= nc_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Ratio theta / r as (theta << 20) / r, one quotient bit per stage.
  // ---------------------------------------------------------------------
  div2_t d2_q [0:fdm_pkg::DIV_STEPS];
  div2_t d2_d0;

  always_comb begin
    d2_d0       = '0;
    d2_d0.sd    = co_q[fdm_pkg::CORDIC_STEPS].sd;
    d2_d0.r     = co_q[fdm_pkg::CORDIC_STEPS].r;
    d2_d0.theta = co_q[fdm_pkg::CORDIC_STEPS].z[32] ? '0
                                                    : co_q[fdm_pkg::CORDIC_STEPS].z[30:0];
    d2_d0.ov    = {12'b0, d2_d0.theta} >= {d2_d0.r, 11'b0};
    d2_d0.rem   = 32'(d2_d0.theta[30:11]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q[0] <= d2_d0;
    end
  end

  for (genvar k = 0; k < fdm_pkg::DIV_STEPS; k++) begin : g_div2
    localparam int B = fdm_pkg::DIV_STEPS - 1 - k;
    logic        bt;
    logic [32:0] trem;
    div2_t       nd_d;

    if (B >= fdm_pkg::NORM_FRAC) begin : g_bit
      assign bt = d2_q[k].theta[B - fdm_pkg::NORM_FRAC];
    end else begin : g_zero
      assign bt = 1'b0;
    end

    always_comb begin
      nd_d = d2_q[k];
      trem = {d2_q[k].rem, bt};
      if (trem >= {1'b0, d2_q[k].r}) begin
        nd_d.rem = 32'(trem - {1'b0, d2_q[k].r});
        nd_d.q   = {d2_q[k].q[29:0], 1'b1};
      end else begin
        nd_d.rem = trem[31:0];
        nd_d.q   = {d2_q[k].q[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d2_q[k+1] <= nd_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Distortion polynomial in theta, then the scale and the offsets.
  // ---------------------------------------------------------------------
  div2_t d2_last;
  assign d2_last = d2_q[fdm_pkg::DIV_STEPS];

  logic [26:0] t_w;
  logic [53:0] tt_w;
  logic [55:0] t4p_w;
  logic [56:0] t6p_w;
  logic [57:0] t8p_w;

  side_t sd1_q, sd2_q, sd3_q, sd4_q, sd5_q, sd6_q, sd7_q, sd8_q, sd9_q;
  logic [30:0] s1_q, s2_q, s3_q, s4_q, s5_q, s6_q;
  logic [27:0] t2_1_q, t2_2_q;
  logic [28:0] t4_2_q;
  logic [29:0] t6_3_q;
  logic [31:0] t8_3_q;
  logic signed [60:0] p1_2_q, p1_3_q, p1_4_q;
  logic signed [61:0] p2_3_q, p2_4_q;
  logic signed [62:0] p3_4_q;
  logic signed [64:0] p4_4_q;
  logic signed [64:0] psum_w;
  logic signed [42:0] p_5_q;
  logic [41:0] pabs_6_q;
  logic        pneg_6_q, pneg_7_q, pneg_8_q, pneg_9_q;
  logic [60:0] mlo_7_q;
  logic [42:0] mhi_7_q;
  logic [42:0] scale_8_q;
  logic [53:0] oxl_9_q, oyl_9_q;
  logic [36:0] oxh_9_q, oyh_9_q;
  logic [37:0] offx_q, offy_q;
  logic        subx_q, suby_q;

  assign t_w    = d2_last.theta[30:4];
  assign tt_w   = t_w * t_w;
  assign t4p_w  = t2_1_q * t2_1_q;
  assign t6p_w  = t4_2_q * t2_2_q;
  assign t8p_w  = t4_2_q * t4_2_q;
  assign psum_w = $signed(65'sh4000_0000) + (p1_4_q >>> 24) + (p2_4_q >>> 24)
                + (p3_4_q >>> 24) + (p4_4_q >>> 24);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // theta squared; the ratio is limited to 1.0.
      sd1_q  <= d2_last.sd;
      s1_q   <= (d2_last.ov || (d2_last.q > fdm_pkg::ONE_Q30)) ? fdm_pkg::ONE_Q30
                                                                : d2_last.q;
      t2_1_q <= tt_w[53:26];
      // Fourth power and first term.
      sd2_q  <= sd1_q;
      s2_q   <= s1_q;
      t2_2_q <= t2_1_q;
      t4_2_q <= t4p_w[54:26];
      p1_2_q <= $signed(coef_one_q) * $signed({1'b0, t2_1_q});
      // Sixth and eighth powers, second term.
      sd3_q  <= sd2_q;
      s3_q   <= s2_q;
      p1_3_q <= p1_2_q;
      t6_3_q <= t6p_w[55:26];
      t8_3_q <= t8p_w[57:26];
      p2_3_q <= $signed(coef_two_q) * $signed({1'b0, t4_2_q});
      // Third and fourth terms.
      sd4_q  <= sd3_q;
      s4_q   <= s3_q;
      p1_4_q <= p1_3_q;
      p2_4_q <= p2_3_q;
      p3_4_q <= $signed(coef_three_q) * $signed({1'b0, t6_3_q});
      p4_4_q <= $signed(coef_four_q) * $signed({1'b0, t8_3_q});
      // Polynomial sum.
      sd5_q  <= sd4_q;
      s5_q   <= s4_q;
      p_5_q  <= psum_w[42:0];
      // Magnitude and sign.
      sd6_q    <= sd5_q;
      s6_q     <= s5_q;
      pneg_6_q <= p_5_q[42];
      pabs_6_q <= 42'(p_5_q[42] ? -p_5_q : p_5_q);
      // Scale = s * |P| / 2^30, split in two partial products.
      sd7_q    <= sd6_q;
      pneg_7_q <= pneg_6_q;
      mlo_7_q  <= s6_q * pabs_6_q[29:0];
      mhi_7_q  <= s6_q * pabs_6_q[41:30];
      // At zero radius the scale is exactly 1.0 and positive.
      sd8_q     <= sd7_q;
      pneg_8_q  <= sd7_q.zero ? 1'b0 : pneg_7_q;
      scale_8_q <= sd7_q.zero ? 43'(fdm_pkg::ONE_Q30)
                              : 43'(mhi_7_q + 43'(mlo_7_q[60:30]));
      // Offsets |d| * scale / 2^30, again split.
      sd9_q    <= sd8_q;
      pneg_9_q <= pneg_8_q;
      oxl_9_q  <= sd8_q.ax * scale_8_q[29:0];
      oxh_9_q  <= sd8_q.ax * scale_8_q[42:30];
      oyl_9_q  <= sd8_q.ay * scale_8_q[29:0];
      oyh_9_q  <= sd8_q.ay * scale_8_q[42:30];
      offx_q   <= 38'(oxh_9_q) + 38'(oxl_9_q[53:30]);
      offy_q   <= 38'(oyh_9_q) + 38'(oyl_9_q[53:30]);
      subx_q   <= sd9_q.negx ^ pneg_9_q;
      suby_q   <= sd9_q.negy ^ pneg_9_q;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: source position with saturation.
  // ---------------------------------------------------------------------
  localparam logic signed [39:0] OUT_MAX = 40'sd8388607;
  localparam logic signed [39:0] OUT_MIN = -40'sd8388608;

  logic signed [39:0] vx, vy;
  logic [23:0]        sx_d, sy_d, sx_q, sy_q;
  logic               clip_d, clip_q;

  always_comb begin
    vx     = subx_q ? $signed(40'(center_x_q)) - $signed(40'(offx_q))
                    : $signed(40'(center_x_q)) + $signed(40'(offx_q));
    vy     = suby_q ? $signed(40'(center_y_q)) - $signed(40'(offy_q))
                    : $signed(40'(center_y_q)) + $signed(40'(offy_q));
    clip_d = 1'b0;
    sx_d   = vx[23:0];
    sy_d   = vy[23:0];
    if (vx > OUT_MAX) begin
      sx_d   = OUT_MAX[23:0];
      clip_d = 1'b1;
    end else if (vx < OUT_MIN) begin
      sx_d   = OUT_MIN[23:0];
      clip_d = 1'b1;
    end
    if (vy > OUT_MAX) begin
      sy_d   = OUT_MAX[23:0];
      clip_d = 1'b1;
    end else if (vy < OUT_MIN) begin
      sy_d   = OUT_MIN[23:0];
      clip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      clip_q <= clip_d;
    end
  end

  assign m_axis_tdata_o = {sy_q, sx_q};
  assign m_axis_tuser_o = clip_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // A held result freezes every valid bit of the pipeline.
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

  // An accepted input occupies the first slot on the next cycle.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("accepted transfer did not enter the pipeline");

  // A clipped result carries a coordinate at a range limit.
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (sx_q == OUT_MAX[23:0] || sx_q == OUT_MIN[23:0] ||
       sy_q == OUT_MAX[23:0] || sy_q == OUT_MIN[23:0]))
    else $error("clipped flag without a saturated coordinate");

endmodule
